FILE: rtl/zwps_pkg.sv
// ----------------------------------------------------------------------------
// zwps_pkg: zero-cross weld pulse sequencer shared types
// Phase codes, register indexes, state and configuration records.
// ----------------------------------------------------------------------------
`default_nettype none

package zwps_pkg;

  localparam int CountW = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRE_PULSE  = 2'd0,
    REG_PAUSE      = 2'd1,
    REG_WELD       = 2'd2,
    REG_COUNT_MODE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PRE    = 3'd1,
    PH_PAUSE  = 3'd2,
    PH_MAIN   = 3'd3,
    PH_MANUAL = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CountW-1:0] pre_pulse_periods;
    logic [CountW-1:0] pause_periods;
    logic [CountW-1:0] weld_periods;
    logic              pulse_count_mode;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [CountW-1:0] period_count;
    logic              triac_state;
    logic              prev_button;
  } seq_state_t;

endpackage

`default_nettype wire

FILE: rtl/zwps_if.sv
// ----------------------------------------------------------------------------
// zwps_if: sequencer channel interfaces
// Tick channel (crossing flag, button level) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface zwps_in_if;
  logic valid;
  logic ready;
  logic zero_cross;
  logic button_level;

  modport source (output valid, output zero_cross, output button_level, input ready);
  modport sink (input valid, input zero_cross, input button_level, output ready);
endinterface

interface zwps_out_if;
  logic valid;
  logic ready;
  logic triac_on;
  logic led_on;
  logic busy_res;

  modport source (output valid, output triac_on, output led_on, output busy_res,
                  input ready);
  modport sink (input valid, input triac_on, input led_on, input busy_res,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/zwps_cfg_regs.sv
// ----------------------------------------------------------------------------
// zwps_cfg_regs: configuration register file
// Pulse counts and mode, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module zwps_cfg_regs
  import zwps_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                we,
  input  wire logic [CfgIdxW-1:0]  idx,
  input  wire logic [CfgDataW-1:0] wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (reg_idx_t'(idx))
        REG_PRE_PULSE:  cfg_nxt.pre_pulse_periods = wdata;
        REG_PAUSE:      cfg_nxt.pause_periods = wdata;
        REG_WELD:       cfg_nxt.weld_periods = wdata;
        REG_COUNT_MODE: cfg_nxt.pulse_count_mode = wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_pulse_periods <= '0;
      cfg_r.pause_periods     <= '0;
      cfg_r.weld_periods      <= CountW'(1);
      cfg_r.pulse_count_mode  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/zwps_step.sv
// ----------------------------------------------------------------------------
// zwps_step: per-tick sequencer update
// Next phase, crossing count and triac state from one registered tick.
// ----------------------------------------------------------------------------
`default_nettype none

module zwps_step
  import zwps_pkg::*;
(
  input  wire cfg_t       cfg,
  input  wire seq_state_t cur,
  input  wire logic       zero_cross,
  input  wire logic       button_level,
  output seq_state_t      nxt
);

  logic [CountW:0]   inc;
  logic [CountW-1:0] inc_sat;
  logic [CountW-1:0] limit;
  logic              reached;
  phase_t            xph;

  always_comb begin
    nxt = cur;
    xph = cur.phase;
    if (cur.phase == PH_PRE && cfg.pre_pulse_periods == '0) begin
      xph = PH_MAIN;
    end
    unique case (xph)
      PH_PRE:   limit = cfg.pre_pulse_periods;
      PH_PAUSE: limit = cfg.pause_periods;
      default:  limit = cfg.weld_periods;
    endcase
    inc     = {1'b0, cur.period_count} + (CountW+1)'(1);
    inc_sat = inc[CountW] ? {CountW{1'b1}} : inc[CountW-1:0];
    // pre-skip clears the count before the increment
    if (xph != cur.phase) begin
      inc     = (CountW+1)'(1);
      inc_sat = CountW'(1);
    end
    reached = (inc >= {1'b0, limit});

    unique case (cur.phase)
      PH_IDLE: begin
        nxt.prev_button = button_level;
        if (button_level && !cur.prev_button) begin
          nxt.prev_button = 1'b1;
          if (cfg.pulse_count_mode) begin
            nxt.phase       = PH_PRE;
            nxt.triac_state = 1'b0;
          end else begin
            nxt.phase       = PH_MANUAL;
            nxt.triac_state = 1'b1;
          end
        end else if (zero_cross) begin
          nxt.triac_state = 1'b0;
        end
      end
      PH_MANUAL: begin
        if (!button_level) begin
          nxt.triac_state = 1'b0;
          nxt.phase       = PH_IDLE;
        end
      end
      PH_PRE, PH_PAUSE, PH_MAIN: begin
        if (zero_cross) begin
          nxt.phase = xph;
          if (xph != cur.phase) begin
            nxt.period_count = '0;
          end
          case (xph)
            PH_PRE: begin
              if (!cur.triac_state) begin
                nxt.period_count = '0;
                nxt.triac_state  = 1'b1;
              end else begin
                nxt.period_count = inc_sat;
                if (reached) begin
                  nxt.triac_state  = 1'b0;
                  nxt.period_count = '0;
                  nxt.phase        = PH_PAUSE;
                end
              end
            end
            PH_PAUSE: begin
              nxt.period_count = inc_sat;
              if (reached) begin
                nxt.period_count = '0;
                nxt.phase        = PH_MAIN;
              end
            end
            default: begin
              if (!cur.triac_state) begin
                nxt.period_count = '0;
                nxt.triac_state  = 1'b1;
              end else begin
                nxt.period_count = inc_sat;
                if (reached) begin
                  nxt.triac_state = 1'b0;
                  nxt.phase       = PH_IDLE;
                end
              end
            end
          endcase
        end
      end
      default: begin
        nxt.phase       = PH_IDLE;
        nxt.triac_state = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/zero_cross_weld_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// zero_cross_weld_pulse_sequencer: triac weld pulse sequencer
// Counts mains zero crossings through pre pulse, pause and main pulse, or
// drives the triac directly while the button is held in manual mode.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          beat when
//  in_ch    in   zero_cross, button_level         valid && ready
//  out_ch   out  triac_on, led_on, busy_res       valid && ready
//  cfg_*    in   cfg_idx, cfg_wdata (8 bit)       cfg_we
//
//  One tick per clock unless out_ch stalls: tick register, sequencer update,
//  result register; an input beat passes through both before its result beat.
//  in_ch.ready is high whenever the tick register is empty or drains into
//  the result register; an output stall backs up one tick in each stage.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_cross_weld_pulse_sequencer
  import zwps_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  zwps_in_if.sink                  in_ch,
  zwps_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t       cfg;
  seq_state_t state_r, state_nxt;

  logic tick_vld_r;
  logic tick_zc_r;
  logic tick_btn_r;
  logic res_vld_r;
  logic res_triac_r;
  logic res_busy_r;
  logic res_adv;
  logic tick_adv;
  logic in_fire;

  zwps_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  zwps_step u_step (
    .cfg          (cfg),
    .cur          (state_r),
    .zero_cross   (tick_zc_r),
    .button_level (tick_btn_r),
    .nxt          (state_nxt)
  );

  assign res_adv  = !res_vld_r || out_ch.ready;
  assign tick_adv = tick_vld_r && res_adv;
  assign in_ch.ready = !tick_vld_r || res_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r            <= 1'b0;
      res_vld_r             <= 1'b0;
      state_r.phase         <= PH_IDLE;
      state_r.period_count  <= '0;
      state_r.triac_state   <= 1'b0;
      state_r.prev_button   <= 1'b1;
    end else begin
      if (in_ch.ready) begin
        tick_vld_r <= in_ch.valid;
      end
      if (res_adv) begin
        res_vld_r <= tick_vld_r;
      end
      if (tick_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_zc_r  <= in_ch.zero_cross;
      tick_btn_r <= in_ch.button_level;
    end
    if (tick_adv) begin
      res_triac_r <= state_nxt.triac_state;
      res_busy_r  <= (state_nxt.phase != PH_IDLE);
    end
  end

  assign out_ch.valid    = res_vld_r;
  assign out_ch.triac_on = res_triac_r;
  assign out_ch.led_on   = res_busy_r;
  assign out_ch.busy_res = res_busy_r;

  a_idle_triac_off: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_IDLE |-> !state_r.triac_state)
    else $error("triac on while idle");

  a_pause_triac_off: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_PAUSE |-> !state_r.triac_state)
    else $error("triac on during pause");

  a_pause_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_adv && !tick_zc_r && state_r.phase == PH_PAUSE)
      |=> $stable(state_r.period_count))
    else $error("pause count moved without a crossing");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    tick_adv |=> (res_triac_r == state_r.triac_state) &&
                 (res_busy_r == (state_r.phase != PH_IDLE)))
    else $error("result register out of step with state");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: zero-cross weld pulse sequencer testbench
// Sends crossing/button ticks through the input channel and checks every
// result beat against an in-bench model of the pulse sequence, under random
// gaps on both channels, long output hold-offs and several register settings.
// ----------------------------------------------------------------------------
module tb;
  import zwps_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SqueezeCycles = 90;

  typedef struct packed {
    logic zc;
    logic btn;
  } tick_t;

  typedef struct packed {
    logic triac_on;
    logic led_on;
    logic busy_res;
  } weld_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  zwps_in_if in_if();
  zwps_out_if out_if();

  zero_cross_weld_pulse_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tick_t tick_q[$];
  weld_out_t drive_q[$];

  // sequencer model state
  cfg_t weld_cfg;
  phase_t weld_phase;
  logic [CountW-1:0] weld_count;
  logic gate_state;
  logic btn_last;

  bit quiet = 1'b0;
  int squeeze_req = 0;
  int squeeze_ack;
  int squeeze_left;
  int idle_cycles;
  int send_gap;
  int recv_stall;
  int error_count = 0;
  int tick_count = 0;
  int result_count = 0;
  int weld_starts = 0;
  int cfg_writes = 0;
  int ticks_queued = 0;
  tick_t cur_tick;
  weld_out_t want;
  weld_out_t got;

  function automatic logic count_hits(input logic [CountW-1:0] limit);
    logic [CountW:0] nxt;
    nxt = {1'b0, weld_count} + (CountW+1)'(1);
    weld_count = (nxt > 9'd255) ? 8'd255 : nxt[CountW-1:0];
    return nxt >= {1'b0, limit};
  endfunction

  function automatic void crossing_update();
    if (weld_phase == PH_PRE && weld_cfg.pre_pulse_periods == '0) begin
      weld_count = '0;
      weld_phase = PH_MAIN;
    end
    case (weld_phase)
      PH_PRE: begin
        if (!gate_state) begin
          weld_count = '0;
          gate_state = 1'b1;
        end else if (count_hits(weld_cfg.pre_pulse_periods)) begin
          gate_state = 1'b0;
          weld_count = '0;
          weld_phase = PH_PAUSE;
        end
      end
      PH_PAUSE: begin
        if (count_hits(weld_cfg.pause_periods)) begin
          weld_count = '0;
          weld_phase = PH_MAIN;
        end
      end
      PH_MAIN: begin
        if (!gate_state) begin
          weld_count = '0;
          gate_state = 1'b1;
        end else if (count_hits(weld_cfg.weld_periods)) begin
          gate_state = 1'b0;
          weld_phase = PH_IDLE;
        end
      end
      PH_MANUAL: ;
      default: gate_state = 1'b0;
    endcase
  endfunction

  function automatic weld_out_t weld_step(input logic zc, input logic btn);
    weld_out_t r;
    logic busy;
    case (weld_phase)
      PH_IDLE: begin
        if (btn && !btn_last) begin
          btn_last = 1'b1;
          weld_starts++;
          if (weld_cfg.pulse_count_mode) begin
            weld_phase = PH_PRE;
            gate_state = 1'b0;
          end else begin
            weld_phase = PH_MANUAL;
            gate_state = 1'b1;
          end
        end else begin
          btn_last = btn;
          if (zc) gate_state = 1'b0;
        end
      end
      PH_MANUAL: begin
        if (!btn) begin
          gate_state = 1'b0;
          weld_phase = PH_IDLE;
        end
      end
      PH_PRE, PH_PAUSE, PH_MAIN: begin
        if (zc) crossing_update();
      end
      default: begin
        weld_phase = PH_IDLE;
        gate_state = 1'b0;
      end
    endcase
    busy = (weld_phase != PH_IDLE);
    r.triac_on = gate_state;
    r.led_on = busy;
    r.busy_res = busy;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(input string field, input logic seen, input logic wanted);
    $display("mismatch at result %0d: %s got %0b want %0b", result_count, field, seen,
             wanted);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        cur_tick = tick_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.zero_cross <= cur_tick.zc;
        in_if.button_level <= cur_tick.btn;
        send_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor, model update and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall = 0;
      weld_cfg.pre_pulse_periods = 8'd0;
      weld_cfg.pause_periods = 8'd0;
      weld_cfg.weld_periods = 8'd1;
      weld_cfg.pulse_count_mode = 1'b1;
      weld_phase = PH_IDLE;
      weld_count = '0;
      gate_state = 1'b0;
      btn_last = 1'b1;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_PRE_PULSE: weld_cfg.pre_pulse_periods = cfg_wdata;
          REG_PAUSE: weld_cfg.pause_periods = cfg_wdata;
          REG_WELD: weld_cfg.weld_periods = cfg_wdata;
          REG_COUNT_MODE: weld_cfg.pulse_count_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got.triac_on = out_if.triac_on;
        got.led_on = out_if.led_on;
        got.busy_res = out_if.busy_res;
        if (drive_q.size() == 0) begin
          report_mismatch("unexpected beat", 1'b1, 1'b0);
        end else begin
          want = drive_q.pop_front();
          if (got.triac_on !== want.triac_on)
            report_mismatch("triac_on", got.triac_on, want.triac_on);
          if (got.led_on !== want.led_on) report_mismatch("led_on", got.led_on, want.led_on);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
        end
        result_count++;
      end
      if (in_if.valid && in_if.ready) begin
        drive_q.push_back(weld_step(in_if.zero_cross, in_if.button_level));
        tick_count++;
      end
      if (squeeze_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      squeeze_left <= 0;
      squeeze_ack <= 0;
    end else if (squeeze_left != 0) begin
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_ack != squeeze_req) begin
      squeeze_left <= SqueezeCycles;
      squeeze_ack <= squeeze_ack + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("timeout: no beat for %0d cycles", StallLimit);
      $display("FAIL zero_cross_weld_pulse_sequencer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_tick(input logic zc, input logic btn);
    tick_t t;
    t.zc = zc;
    t.btn = btn;
    tick_q.push_back(t);
    ticks_queued++;
  endfunction

  // release, press, then a run of ticks with the button mostly held
  function automatic void queue_weld(input int len, input int zc_pct);
    push_tick(1'($urandom_range(0, 1)), 1'b0);
    push_tick(1'($urandom_range(0, 1)), 1'b1);
    for (int i = 0; i < len; i++)
      push_tick($urandom_range(0, 99) < zc_pct, $urandom_range(0, 9) != 0);
  endfunction

  function automatic void fill_random(input int target);
    int start;
    start = ticks_queued;
    while (ticks_queued - start < target) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_weld($urandom_range(1, 30), $urandom_range(30, 95));
      end else begin
        repeat ($urandom_range(1, 5))
          push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  function automatic logic [7:0] pick_count();
    if ($urandom_range(0, 5) == 0) return 8'd0;
    return 8'($urandom_range(1, 4));
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (tick_q.size() != 0 || in_if.valid || drive_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] pre, input logic [7:0] pause,
                          input logic [7:0] weld, input logic mode);
    write_reg(REG_PRE_PULSE, pre);
    write_reg(REG_PAUSE, pause);
    write_reg(REG_WELD, weld);
    write_reg(REG_COUNT_MODE, {7'd0, mode});
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.zero_cross = 1'b0;
    in_if.button_level = 1'b0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: button held from reset, crossing on the start tick,
    // zero pre count, button ignored mid-sequence, crossing while idle
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    wait_drained();

    // manual weld, crossings have no effect
    set_regs(8'd1, 8'd0, 8'd0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    wait_drained();

    // zero pause and zero weld counts each still take one crossing
    write_reg(REG_COUNT_MODE, 8'd1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph % 3 == 1);
      case (ph)
        0: begin
          set_regs(8'd255, 8'd0, 8'd255, 1'b1);
          queue_weld(520, 100);
        end
        1: begin
          set_regs(8'd1, 8'd255, 8'd0, 1'b1);
          queue_weld(265, 95);
        end
        2: begin
          set_regs(pick_count(), pick_count(), pick_count(), 1'b0);
          fill_random(25);
        end
        default: begin
          set_regs(pick_count(), pick_count(), pick_count(), $urandom_range(0, 4) != 0);
          fill_random(25);
        end
      endcase
      if (ph == 3 || ph == 6) begin
        @(negedge clk);
        squeeze_req++;
      end
      wait_drained();
    end

    repeat (6) @(posedge clk);
    $display("run covered %0d ticks, %0d results, %0d weld starts, %0d register writes",
             tick_count, result_count, weld_starts, cfg_writes);
    $display("settings included count extremes 0 and 255, manual mode and output hold-offs");
    if (error_count == 0) begin
      $display("PASS zero_cross_weld_pulse_sequencer");
    end else begin
      $display("FAIL zero_cross_weld_pulse_sequencer");
    end
    $finish;
  end

endmodule
